// ===== rtl/hqe_pkg.sv =====
// Shared constants, types and helper functions for the histogram quantile engine.
`default_nettype none

package hqe_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_SAMPLES   = 1048576;
    localparam int NUM_QUANTILES = 4;
    localparam int FRACTION_BITS = 16;

    localparam int SAMPLE_W    = 16;
    localparam int BIN_W       = SAMPLE_BITS;
    localparam int NUM_BINS    = 1 << BIN_W;
    localparam int BIN_OFFSET  = 1 << (BIN_W - 1);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int FRAC_W      = FRACTION_BITS + 1;
    localparam int PROD_W      = FRAC_W + CNT_W;
    localparam int QUERY_SLOTS = 4;
    localparam int QIDX_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int S_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((SAMPLE_W + QIDX_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - SAMPLE_W - QIDX_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRACTION_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_D     = 3'd4;

    typedef struct packed {
        logic              sample_take;
        logic              walk_start;
        logic              walk_scan;
        logic              thr_load;
        logic [QIDX_W-1:0] qidx;
    } hqe_cmd_t;

    typedef struct packed {
        logic              walk_busy;
        logic [QCNT_W-1:0] eff_count;
    } hqe_status_t;

    // Saturate a raw sample to the bin range and offset it to an unsigned bin index.
    function automatic logic [BIN_W-1:0] to_bin(input logic [SAMPLE_W-1:0] raw);
        int v;
        v = int'($signed(raw));
        if (v < -BIN_OFFSET) v = -BIN_OFFSET;
        if (v > BIN_OFFSET - 1) v = BIN_OFFSET - 1;
        return BIN_W'(v + BIN_OFFSET);
    endfunction

    // Map a bin index back to its signed sample value.
    function automatic logic [SAMPLE_W-1:0] bin_to_value(input logic [BIN_W-1:0] bin);
        logic signed [BIN_W-1:0] sv;
        sv = $signed({~bin[BIN_W-1], bin[BIN_W-2:0]});
        return SAMPLE_W'(sv);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hqe_ctrl.sv =====
// Sequencer for counting, threshold setup, histogram walk and result delivery.
`default_nettype none

module hqe_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic                     m_tlast,
    output hqe_pkg::hqe_cmd_t        cmd,
    input  wire hqe_pkg::hqe_status_t status
);
    import hqe_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR_GO,
        ST_CLR,
        ST_COUNT,
        ST_THRESH,
        ST_SCAN_GO,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [QIDX_W-1:0] qidx_reg;
    logic              s_tready_reg;
    logic              m_tvalid_reg;
    logic              take;
    logic              last_query;

    assign take       = s_tvalid && s_tready_reg;
    assign last_query = ({1'b0, qidx_reg} == status.eff_count - QCNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR_GO;
            qidx_reg     <= '0;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLR_GO: begin
                    state_reg <= ST_CLR;
                end
                ST_CLR: begin
                    if (!status.walk_busy) begin
                        state_reg    <= ST_COUNT;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_COUNT: begin
                    if (take && s_tlast) begin
                        state_reg    <= ST_THRESH;
                        s_tready_reg <= 1'b0;
                        qidx_reg     <= '0;
                    end
                end
                ST_THRESH: begin
                    // one threshold per cycle through the shared multiplier
                    if (qidx_reg == QIDX_W'(QUERY_SLOTS - 1)) begin
                        state_reg <= ST_SCAN_GO;
                        qidx_reg  <= '0;
                    end else begin
                        qidx_reg <= qidx_reg + QIDX_W'(1);
                    end
                end
                ST_SCAN_GO: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (!status.walk_busy) begin
                        state_reg    <= ST_EMIT;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (last_query) begin
                            state_reg    <= ST_COUNT;
                            m_tvalid_reg <= 1'b0;
                            s_tready_reg <= 1'b1;
                            qidx_reg     <= '0;
                        end else begin
                            qidx_reg <= qidx_reg + QIDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_CLR_GO;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_query;

    always_comb begin
        cmd.sample_take = take;
        cmd.walk_start  = (state_reg == ST_CLR_GO) || (state_reg == ST_SCAN_GO);
        cmd.walk_scan   = (state_reg == ST_SCAN_GO);
        cmd.thr_load    = (state_reg == ST_THRESH);
        cmd.qidx        = qidx_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/hqe_datapath.sv =====
// Histogram memory, increment forwarding, threshold multiplier, bin walk and result registers.
`default_nettype none

module hqe_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [hqe_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic      [hqe_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                                cfg_valid,
    input  wire logic [hqe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hqe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire hqe_pkg::hqe_cmd_t                   cmd,
    output hqe_pkg::hqe_status_t                     status
);
    import hqe_pkg::*;

    // configuration
    logic [QCNT_W-1:0] qcount_reg;
    logic [FRAC_W-1:0] frac_reg [QUERY_SLOTS];
    logic [QCNT_W-1:0] eff_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcount_reg  <= QCNT_W'(2);
            frac_reg[0] <= FRAC_W'(13107);
            frac_reg[1] <= FRAC_W'(58982);
            frac_reg[2] <= FRAC_W'(32768);
            frac_reg[3] <= FRAC_W'(32768);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_QUANTILE_COUNT: qcount_reg  <= cfg_data[QCNT_W-1:0];
                REG_FRACTION_A:     frac_reg[0] <= cfg_data[FRAC_W-1:0];
                REG_FRACTION_B:     frac_reg[1] <= cfg_data[FRAC_W-1:0];
                REG_FRACTION_C:     frac_reg[2] <= cfg_data[FRAC_W-1:0];
                REG_FRACTION_D:     frac_reg[3] <= cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_count = qcount_reg;
        if (qcount_reg == '0)
            eff_count = QCNT_W'(1);
        else if (qcount_reg > QCNT_W'(NUM_QUANTILES))
            eff_count = QCNT_W'(NUM_QUANTILES);
    end

    // histogram memory
    logic [CNT_W-1:0] mem [NUM_BINS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [BIN_W-1:0] rd_addr;
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    // sample count and increment pipeline
    logic [BIN_W-1:0] bin_in;
    logic             count_ok;
    logic [CNT_W-1:0] total_reg;
    logic             p1_valid_reg;
    logic [BIN_W-1:0] p1_bin_reg;
    logic             lw_valid_reg;
    logic [BIN_W-1:0] lw_addr_reg;
    logic [CNT_W-1:0] lw_val_reg;
    logic [CNT_W-1:0] inc_val;

    assign bin_in   = to_bin(s_tdata[SAMPLE_W-1:0]);
    assign count_ok = total_reg < CNT_W'(MAX_SAMPLES);
    // forward the previous write when it hit the same bin
    assign inc_val  = ((lw_valid_reg && lw_addr_reg == p1_bin_reg) ? lw_val_reg : rd_data_reg)
                      + CNT_W'(1);

    // walk over all bins: scan and clear
    logic                   walk_active_reg;
    logic [BIN_W-1:0]       walk_addr_reg;
    logic                   wv_reg;
    logic [BIN_W-1:0]       wa_reg;
    logic                   scan_mode_reg;
    logic [CNT_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       sum_next;
    logic [QUERY_SLOTS-1:0] found_reg;
    logic [QUERY_SLOTS-1:0] hit;
    logic [BIN_W-1:0]       res_reg [QUERY_SLOTS];
    logic [CNT_W-1:0]       thr_reg [QUERY_SLOTS];

    assign sum_next = sum_reg + rd_data_reg;

    always_comb begin
        for (int q = 0; q < QUERY_SLOTS; q++) begin
            hit[q] = wv_reg && scan_mode_reg && !found_reg[q] && (sum_next > thr_reg[q]);
        end
    end

    assign rd_addr   = walk_active_reg ? walk_addr_reg : bin_in;
    assign mem_we    = p1_valid_reg || wv_reg;
    assign mem_waddr = p1_valid_reg ? p1_bin_reg : wa_reg;
    assign mem_wdata = p1_valid_reg ? inc_val : '0;

    // threshold = floor(min(q, 1) * (n - 1))
    logic [FRAC_W-1:0] frac_sel;
    logic [FRAC_W-1:0] frac_clamp;
    logic [CNT_W-1:0]  nm1;
    logic [PROD_W-1:0] prod;

    assign frac_sel   = frac_reg[cmd.qidx];
    assign frac_clamp = (frac_sel > FRAC_ONE) ? FRAC_ONE : frac_sel;
    assign nm1        = (total_reg != '0) ? total_reg - CNT_W'(1) : '0;
    assign prod       = PROD_W'(frac_clamp) * PROD_W'(nm1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= '0;
            p1_valid_reg    <= 1'b0;
            lw_valid_reg    <= 1'b0;
            walk_active_reg <= 1'b0;
            walk_addr_reg   <= '0;
            wv_reg          <= 1'b0;
            scan_mode_reg   <= 1'b0;
            found_reg       <= '0;
        end else begin
            p1_valid_reg <= cmd.sample_take && count_ok;
            if (cmd.sample_take && count_ok)
                total_reg <= total_reg + CNT_W'(1);

            if (p1_valid_reg)
                lw_valid_reg <= 1'b1;
            else if (wv_reg)
                lw_valid_reg <= 1'b0;

            if (cmd.walk_start) begin
                walk_active_reg <= 1'b1;
                walk_addr_reg   <= '0;
                scan_mode_reg   <= cmd.walk_scan;
                total_reg       <= '0;
            end else if (walk_active_reg) begin
                walk_addr_reg <= walk_addr_reg + BIN_W'(1);
                if (&walk_addr_reg)
                    walk_active_reg <= 1'b0;
            end
            wv_reg <= walk_active_reg;

            found_reg <= cmd.walk_start ? '0 : (found_reg | hit);
        end
    end

    always_ff @(posedge aclk) begin
        p1_bin_reg <= bin_in;
        wa_reg     <= walk_addr_reg;
        if (p1_valid_reg) begin
            lw_addr_reg <= p1_bin_reg;
            lw_val_reg  <= inc_val;
        end
        if (cmd.thr_load)
            thr_reg[cmd.qidx] <= prod[FRACTION_BITS +: CNT_W];
        if (cmd.walk_start) begin
            sum_reg <= '0;
            for (int q = 0; q < QUERY_SLOTS; q++) res_reg[q] <= '1;
        end else begin
            if (wv_reg && scan_mode_reg)
                sum_reg <= sum_next;
            for (int q = 0; q < QUERY_SLOTS; q++) begin
                if (hit[q])
                    res_reg[q] <= wa_reg;
            end
        end
    end

    assign status = '{walk_busy: walk_active_reg || wv_reg, eff_count: eff_count};

    assign m_tdata = {{M_PAD_W{1'b0}}, cmd.qidx, bin_to_value(res_reg[cmd.qidx])};

endmodule

`default_nettype wire

// ===== rtl/histogram_quantile_engine.sv =====
// Top level of the histogram quantile engine: sequencer plus datapath.
//
// Usage:
//   Samples enter on the s_ stream; s_tdata[15:0] is the signed sample and
//   s_tlast marks the final sample of a data set. A request is taken at each
//   rising edge with s_tvalid and s_tready high; while counting, one sample
//   is taken every cycle (read-modify-write of the bin with forwarding).
//   After the sample with s_tlast, the block stops taking samples, computes
//   four thresholds (one shared 17x21 multiplier), then walks all 65536
//   bins once (one memory read and one write a cycle), resolving every
//   configured quantile and zeroing each bin as it passes. Then it presents
//   1 to 4 results on the m_ stream in query order, m_tlast on the final
//   one; a stalled receiver simply holds the current result. Sampling
//   resumes after the final result is taken. Reset (aresetn low,
//   synchronous) restores the configuration defaults and then runs a
//   clearing walk over the histogram before s_tready rises. Configuration
//   writes (cfg_valid/cfg_index/cfg_data) are always taken; write them only
//   while the block is idle.
`default_nettype none

module histogram_quantile_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: [15:0] sample
    input  wire logic [hqe_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: [15:0] quantile_value, [17:16] query_index, upper bits zero
    output logic      [hqe_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hqe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hqe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hqe_pkg::*;

    hqe_cmd_t    cmd;
    hqe_status_t status;

    // configuration registers accept a request on every cycle
    assign cfg_ready = 1'b1;

    hqe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    hqe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
